// ===== design/agh_pkg.sv =====
// Shared types, constants and the word transform for the name hash block.
`default_nettype none
package agh_pkg;

  localparam int QDEPTH = 8;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [31:0] MSG_MUL_LO = 32'hC4D9_6501;
  localparam logic [11:0] MSG_MUL_HI = 12'hFB8;
  localparam logic [26:0] ACC_MUL    = 27'h633_D5F1;
  localparam logic [31:0] LEN_MUL_LO = 32'h12AA_7333;
  localparam logic [23:0] LEN_MUL_HI = 24'hAE_5028;

  localparam logic [31:0] ONES32   = 32'h0101_0101;
  localparam logic [31:0] HIGHS32  = 32'h8080_8080;
  localparam logic [31:0] BSLASH32 = 32'h5C5C_5C5C;
  localparam logic [31:0] CASE32   = 32'hDFDF_DFDF;
  localparam logic [31:0] BS_DELTA = 32'd45;

  localparam int MSG_SHIFT = 24;
  localparam int MIX_SHIFT = 61;

  typedef struct packed {
    logic        last;
    logic [63:0] term;
  } agh_entry_t;

  // backslash -> slash and case fold, byte-parallel (borrows across bytes are intended)
  function automatic logic [31:0] fold_word(input logic [31:0] w);
    logic [31:0] t;
    logic [31:0] tm;
    logic [31:0] sel;
    logic [31:0] adj;
    t   = w ^ BSLASH32;
    tm  = t - ONES32;
    sel = ((~t) >> 7) & (tm >> 7) & ONES32;
    adj = 32'(sel * BS_DELTA);
    return (w - adj) & CASE32;
  endfunction

endpackage
`default_nettype wire

// ===== design/asset_name_guid_hash.sv =====
// Top level of the name hash block: front unit, queue and back unit.
// Takes one 32-bit name word per cycle while in_stall is low, and emits one 64-bit
// guid for the word that holds the terminator once it has passed the front stages,
// the queue and the output register. The rate is set by the back unit's accumulator
// loop (multiply by a constant, add, xor fold); the message and length products are
// formed ahead in three front stages. Input stall rises when the front stages plus
// the 8-entry queue hold eight words, which happens only while the output is stalled.
`default_nettype none
module asset_name_guid_hash (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_name_word,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      out_guid
);
  import agh_pkg::*;

  logic              wr_en;
  agh_entry_t        wr_data;
  logic              rd_en;
  agh_entry_t        rd_data;
  logic              rd_valid;
  logic [QCNT_W-1:0] q_count;

  agh_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_name_word (in_name_word),
    .q_count      (q_count),
    .wr_en        (wr_en),
    .wr_data      (wr_data)
  );

  agh_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (wr_en),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_data  (rd_data),
    .rd_valid (rd_valid),
    .count    (q_count)
  );

  agh_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (rd_data),
    .head_valid (rd_valid),
    .pop        (rd_en),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_guid   (out_guid)
  );

endmodule
`default_nettype wire

// ===== design/agh_front.sv =====
// Front unit: classifies each word, tracks name length, precomputes the message term.
`default_nettype none
module agh_front (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [31:0]               in_name_word,
  input  wire logic [agh_pkg::QCNT_W-1:0] q_count,
  output logic                           wr_en,
  output agh_pkg::agh_entry_t            wr_data
);
  import agh_pkg::*;

  logic              accept;
  logic [QCNT_W:0]   occ;

  logic [31:0] v;
  logic [31:0] zmask;
  logic [31:0] lowbit;
  logic [31:0] below;
  logic        is_last;
  logic [1:0]  extra;

  logic [31:0] cnt_r, cnt_nxt;

  // stage 1: operands
  logic        s1_v_r;
  logic        s1_last_r;
  logic [31:0] s1_op_r;
  logic [31:0] s1_len_r;

  // stage 2: partial products
  logic        s2_v_r;
  logic        s2_last_r;
  logic [63:0] s2_pm_lo_r;
  logic [31:0] s2_pm_hi_r;
  logic [63:0] s2_pl_lo_r;
  logic [31:0] s2_pl_hi_r;
  logic [31:0] pm_hi;
  logic [31:0] pl_hi;
  logic [63:0] pm_lo;
  logic [63:0] pl_lo;

  // stage 3: summed products
  logic        s3_v_r;
  logic        s3_last_r;
  logic [39:0] s3_msg_r;
  logic [63:0] s3_plen_r;
  logic [63:0] msg_prod;
  logic [63:0] len_prod;

  // credit window covers the queue and every word still in the front stages
  assign occ = (QCNT_W+1)'(q_count) + (QCNT_W+1)'(s1_v_r) + (QCNT_W+1)'(s2_v_r)
             + (QCNT_W+1)'(s3_v_r);
  assign in_stall = occ >= (QCNT_W+1)'(QDEPTH);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    v       = fold_word(in_name_word);
    zmask   = (~in_name_word) & (in_name_word - ONES32) & HIGHS32;
    is_last = zmask != 32'd0;
    lowbit  = zmask & (32'd0 - zmask);
    below   = lowbit - 32'd1;
    extra   = {lowbit[31] | lowbit[23], lowbit[31] | lowbit[15]};
    cnt_nxt = cnt_r;
    if (accept) begin
      cnt_nxt = is_last ? 32'd0 : cnt_r + 32'd4;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 32'd0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      s1_v_r <= accept;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  // upper partial products land at bit 32, so only their low 32 bits survive mod 2^64
  always_comb begin
    pm_lo    = s1_op_r * MSG_MUL_LO;
    pm_hi    = 32'(s1_op_r * MSG_MUL_HI);
    pl_lo    = s1_len_r * LEN_MUL_LO;
    pl_hi    = 32'(s1_len_r * LEN_MUL_HI);
    msg_prod = s2_pm_lo_r + {s2_pm_hi_r, 32'd0};
    len_prod = s2_pl_lo_r + {s2_pl_hi_r, 32'd0};
  end

  always_ff @(posedge clk) begin
    s1_last_r  <= is_last;
    s1_op_r    <= is_last ? (v & below) : v;
    s1_len_r   <= cnt_r + 32'(extra);
    s2_last_r  <= s1_last_r;
    s2_pm_lo_r <= pm_lo;
    s2_pm_hi_r <= pm_hi;
    s2_pl_lo_r <= pl_lo;
    s2_pl_hi_r <= pl_hi;
    s3_last_r  <= s2_last_r;
    s3_msg_r   <= msg_prod[63:MSG_SHIFT];
    s3_plen_r  <= len_prod;
  end

  always_comb begin
    wr_en        = s3_v_r;
    wr_data.last = s3_last_r;
    wr_data.term = s3_last_r ? (64'(s3_msg_r) - s3_plen_r) : 64'(s3_msg_r);
  end

endmodule
`default_nettype wire

// ===== design/agh_queue.sv =====
// Short FIFO between the front and back units.
`default_nettype none
module agh_queue (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       wr_en,
  input  wire agh_pkg::agh_entry_t        wr_data,
  input  wire logic                       rd_en,
  output agh_pkg::agh_entry_t             rd_data,
  output logic                            rd_valid,
  output logic [agh_pkg::QCNT_W-1:0]      count
);
  import agh_pkg::*;

  agh_entry_t        mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign rd_data  = mem_r[rd_ptr_r];
  assign rd_valid = count_r != '0;
  assign count    = count_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      count_r <= count_r + QCNT_W'(wr_en) - QCNT_W'(rd_en);
    end
  end

endmodule
`default_nettype wire

// ===== design/agh_back.sv =====
// Back unit: accumulator multiply-add loop and the output register.
`default_nettype none
module agh_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire agh_pkg::agh_entry_t head,
  input  wire logic                head_valid,
  output logic                     pop,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [63:0]              out_guid
);
  import agh_pkg::*;

  logic [63:0] acc_r, acc_nxt;
  logic        out_valid_r;
  logic [63:0] out_guid_r;
  logic [58:0] ka_lo;
  logic [31:0] ka_hi;
  logic [63:0] x;
  logic        out_free;

  assign out_free = !out_valid_r || !out_stall;
  assign pop      = head_valid && (!head.last || out_free);

  always_comb begin
    ka_lo   = acc_r[31:0] * ACC_MUL;
    ka_hi   = 32'(acc_r[63:32] * ACC_MUL);
    x       = 64'(ka_lo) + {ka_hi, 32'd0} + head.term;
    acc_nxt = acc_r;
    if (pop) begin
      acc_nxt = head.last ? 64'd0 : (x ^ (x >> MIX_SHIFT));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= 64'd0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r <= acc_nxt;
      if (pop && head.last) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.last) begin
      out_guid_r <= x;
    end
  end

  assign out_valid = out_valid_r;
  assign out_guid  = out_guid_r;

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
// Testbench for asset_name_guid_hash: directed table, random names, guid checks.
`timescale 1ns / 100ps

module testbench;

  localparam logic [63:0] K_MSG = 64'h0000_0FB8_C4D9_6501;
  localparam logic [63:0] K_ACC = 64'h0000_0000_0633_D5F1;
  localparam logic [63:0] K_LEN = 64'h00AE_5028_12AA_7333;
  localparam int N_WORDS = 1350;
  localparam int HOLD_CYCLES = 300;
  localparam int N_DIR = 21;

  typedef struct packed {
    logic [31:0] word;
    logic        fixed;
    logic [63:0] guid;
  } dir_row_t;

  // fixed rows end a name from cleared state with nothing below the terminator
  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    '{32'h0000_0000, 1'b1, 64'h0},  // empty name right after reset
    '{32'hFFFF_FF00, 1'b1, 64'h0},  // empty name, junk above terminator
    '{32'hFFFF_FFFF, 1'b0, 64'h0},
    '{32'h8080_8080, 1'b0, 64'h0},
    '{32'h00FF_FFFF, 1'b0, 64'h0},  // terminator in top lane
    '{32'h5C5C_5C00, 1'b1, 64'h0},  // backslashes above terminator are masked
    '{32'h5C5C_5C5C, 1'b0, 64'h0},
    '{32'h5D5D_5D5C, 1'b0, 64'h0},  // borrow misdetects bytes above a backslash
    '{32'h0000_005C, 1'b0, 64'h0},
    '{32'h6463_6261, 1'b0, 64'h0},
    '{32'h7A7A_7A7A, 1'b0, 64'h0},
    '{32'h2020_2020, 1'b0, 64'h0},
    '{32'hFF00_FFFF, 1'b0, 64'h0},
    '{32'h0101_0101, 1'b0, 64'h0},
    '{32'h7F7F_7F7F, 1'b0, 64'h0},
    '{32'hFEFE_FEFE, 1'b0, 64'h0},
    '{32'hDFDF_DFDF, 1'b0, 64'h0},
    '{32'h0001_0101, 1'b0, 64'h0},
    '{32'h0000_0000, 1'b1, 64'h0},
    '{32'h5C00_5C5C, 1'b0, 64'h0},
    '{32'h0000_002F, 1'b0, 64'h0}
  };

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_name_word;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] out_guid;

  asset_name_guid_hash u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_name_word(in_name_word),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_guid    (out_guid)
  );

  logic [63:0] hash_acc;
  logic [31:0] name_len;
  logic [63:0] guid_q[$];
  logic [63:0] want_guid;

  int  n_fail;
  int  n_guids;
  int  words_sent;
  int  burst_left;
  int  gap_len;
  int  n_in_held;
  int  stall_mode;
  int  mode_left;
  int  mode_cnt;
  bit  hold_req;
  bit  hold_done;

  always #2 clk = ~clk;

  // backslash to slash via the word-wide zero-byte trick, then clear bit 5 of each byte
  function automatic logic [31:0] fold_case(input logic [31:0] w);
    logic [31:0] t;
    logic [31:0] hit;
    t   = w ^ 32'h5C5C_5C5C;
    hit = ((~t) >> 7) & ((t - 32'h0101_0101) >> 7) & 32'h0101_0101;
    return (w - hit * 32'd45) & 32'hDFDF_DFDF;
  endfunction

  // advances the hash state by one word; returns 1 when the word ends a name
  function automatic bit hash_word(input logic [31:0] w, output logic [63:0] guid);
    logic [31:0] v;
    logic [31:0] keep;
    logic [31:0] len;
    logic [63:0] prod;
    logic [63:0] x;
    int          lane;
    v    = fold_case(w);
    lane = -1;
    guid = '0;
    for (int b = 3; b >= 0; b--) begin
      if (w[8*b +: 8] == 8'h00) lane = b;
    end
    if (lane < 0) begin
      prod     = K_MSG * {32'h0, v};
      x        = (prod >> 24) + K_ACC * hash_acc;
      hash_acc = x ^ (x >> 61);
      name_len = name_len + 32'd4;
      return 1'b0;
    end
    keep     = (32'h1 << (8 * lane + 7)) - 32'h1;
    len      = name_len + 32'(lane);
    prod     = K_MSG * {32'h0, v & keep};
    guid     = K_ACC * hash_acc + (prod >> 24) - K_LEN * {32'h0, len};
    hash_acc = '0;
    name_len = '0;
    return 1'b1;
  endfunction

  function automatic logic [7:0] name_byte();
    case ($urandom_range(0, 9))
      0, 1:    return 8'h5C;
      2:       return 8'h5D;
      3, 4:    return 8'h61 + 8'($urandom_range(0, 25));
      5:       return 8'h41 + 8'($urandom_range(0, 25));
      6:       return 8'h2F;
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  task automatic report_fail(input string what, input logic [63:0] want, input logic [63:0] got);
    if (n_fail < 10) begin
      $display("%0t: %s: expected %h, got %h", $realtime, what, want, got);
    end
    n_fail++;
  endtask

  // one word transfer, with bursts and gaps on the sending side
  task automatic send_word(input logic [31:0] w, input logic fixed, input logic [63:0] fixed_guid);
    logic [63:0] guid;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250) : $urandom_range(1, 30);
      gap_len    = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap_len > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap_len - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    in_name_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    words_sent++;
    if (hash_word(w, guid)) guid_q.push_back(fixed ? fixed_guid : guid);
  endtask

  task automatic send_name(input int n_body);
    logic [31:0] w;
    int          lane;
    for (int i = 0; i < n_body; i++) begin
      for (int b = 0; b < 4; b++) w[8*b +: 8] = name_byte();
      send_word(w, 1'b0, '0);
    end
    lane = $urandom_range(0, 3);
    for (int b = 0; b < 4; b++) begin
      if (b < lane) w[8*b +: 8] = name_byte();
      else if (b == lane) w[8*b +: 8] = 8'h00;
      else w[8*b +: 8] = 8'($urandom_range(0, 255));
    end
    send_word(w, 1'b0, '0);
  endtask

  always @(posedge clk) begin
    if (rst_n && in_valid && in_stall) n_in_held++;
    if (rst_n && out_valid && !out_stall) begin
      if (guid_q.size() == 0) begin
        report_fail("guid with no name pending", '0, out_guid);
      end else begin
        want_guid = guid_q.pop_front();
        n_guids++;
        if (out_guid !== want_guid) report_fail("guid mismatch", want_guid, out_guid);
      end
    end
  end

  // result side: a changing stall pattern, plus one long hold-off to back up the input
  initial begin
    mode_left = 0;
    mode_cnt  = 0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
        out_stall <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          mode_left  = $urandom_range(50, 300);
        end
        mode_left--;
        mode_cnt++;
        case (stall_mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= (mode_cnt % 3 == 0);
        endcase
      end
    end
  end

  initial begin
    #2000000;
    $display("timeout with %0d guids outstanding", guid_q.size());
    $display("testbench failed");
    $finish;
  end

  initial begin
    int pick;
    clk          = 1'b0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_name_word = '0;
    out_stall    = 1'b0;
    hash_acc     = '0;
    name_len     = '0;
    n_fail       = 0;
    n_guids      = 0;
    words_sent   = 0;
    burst_left   = 0;
    n_in_held    = 0;
    hold_req     = 1'b0;
    hold_done    = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < N_DIR; r++) send_word(DIR_ROWS[r].word, DIR_ROWS[r].fixed, DIR_ROWS[r].guid);

    hold_req = 1'b1;
    while (words_sent < N_WORDS) begin
      pick = $urandom_range(0, 19);
      if (pick < 2) send_word($urandom, 1'b0, '0);
      else if (pick < 14) send_name($urandom_range(0, 4));
      else if (pick < 19) send_name($urandom_range(5, 16));
      else send_name($urandom_range(17, 64));
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (guid_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("sent %0d name words, checked %0d guids, %0d failures", words_sent, n_guids, n_fail);
    $display("input backed up for %0d cycles under output stall", n_in_held);
    if (n_fail == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
